[design/mrrf_pkg.sv]
package mrrf_pkg;

  // Input opcodes as they arrive on the request port.
  typedef enum logic [2:0] {
    OP_READ_HOLDING = 3'd0,
    OP_READ_INPUT   = 3'd1,
    OP_WRITE_SINGLE = 3'd2,
    OP_WRITE_MULTI  = 3'd3,
    OP_DATA_WORD    = 3'd4
  } opcode_e;

  // Kind of work handed from the front to the back.
  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_DATA    = 2'd2
  } kind_e;

  // Modbus function codes placed in the frame.
  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_READ_INPUT   = 8'd4;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;
  localparam logic [7:0] FC_WRITE_MULTI  = 8'd16;

  // CRC-16 start value and reflected polynomial.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Default depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One classified request as stored in the queue.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  func_code;
    logic [7:0]  device;
    logic [15:0] reg_address;
    logic [15:0] value;
  } cmd_t;

endpackage

[design/mrrf_front.sv]
module mrrf_front #(
  parameter int unsigned QueueDepth = mrrf_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  logic [2:0]     opcode_i,
  input  logic [7:0]     device_i,
  input  logic [15:0]    reg_address_i,
  input  logic [15:0]    value_i,
  output logic           cmd_valid_o,
  output mrrf_pkg::cmd_t cmd_o,
  input  logic           cmd_take_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  mrrf_pkg::cmd_t  queue_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  mrrf_pkg::cmd_t cmd_new;
  logic           known_op;
  logic           wr_en;
  logic           rd_en;

  // Classify the incoming request; unused opcodes are dropped here.
  always_comb begin
    cmd_new.device      = device_i;
    cmd_new.reg_address = reg_address_i;
    cmd_new.value       = value_i;
    cmd_new.kind        = mrrf_pkg::KIND_REQUEST;
    cmd_new.func_code   = mrrf_pkg::FC_READ_HOLDING;
    known_op            = 1'b1;
    case (opcode_i)
      mrrf_pkg::OP_READ_HOLDING: begin
        cmd_new.func_code = mrrf_pkg::FC_READ_HOLDING;
      end
      mrrf_pkg::OP_READ_INPUT: begin
        cmd_new.func_code = mrrf_pkg::FC_READ_INPUT;
      end
      mrrf_pkg::OP_WRITE_SINGLE: begin
        cmd_new.func_code = mrrf_pkg::FC_WRITE_SINGLE;
      end
      mrrf_pkg::OP_WRITE_MULTI: begin
        cmd_new.kind      = mrrf_pkg::KIND_HEADER;
        cmd_new.func_code = mrrf_pkg::FC_WRITE_MULTI;
      end
      mrrf_pkg::OP_DATA_WORD: begin
        cmd_new.kind = mrrf_pkg::KIND_DATA;
      end
      default: begin
        known_op = 1'b0;
      end
    endcase
  end

  assign full_o      = (count_q == FullCnt);
  assign wr_en       = push_i && !full_o && known_op;
  assign cmd_valid_o = (count_q != '0);
  assign rd_en       = cmd_valid_o && cmd_take_i;
  assign cmd_o       = queue_q[rd_ptr_q];

  // Pointer and fill count updates with explicit wrap.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

  // The fill count never exceeds the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FullCnt)
    else $error("queue fill count beyond depth");

endmodule

[design/mrrf_back.sv]
module mrrf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  mrrf_pkg::cmd_t cmd_i,
  output logic           cmd_take_o,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     tx_byte_o,
  output logic           frame_end_o,
  output logic           last_of_item_o,
  output logic           misuse_o
);

  // One byte step of the reflected CRC-16.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ mrrf_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Frame state.
  logic [15:0] crc_q, crc_d;
  logic [15:0] words_left_q, words_left_d;
  logic        frame_open_q, frame_open_d;

  // Item being emitted.
  logic        active_q, active_d;
  logic [3:0]  idx_q, idx_d;
  logic [3:0]  total_q, total_d;
  logic [2:0]  n_pay_q, n_pay_d;
  logic        restart_q, restart_d;
  logic        feed_q, feed_d;
  logic        misuse_q, misuse_d;
  logic [7:0]  bytes_q [7];
  logic [7:0]  bytes_d [7];

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_fend_q, out_fend_d;
  logic        out_last_q, out_last_d;
  logic        out_mis_q, out_mis_d;

  logic        adv;
  logic        emit;
  logic        last_byte;
  logic        load;
  logic        is_pay;
  logic        is_crc_hi;
  logic [7:0]  cur_byte;
  logic [15:0] crc_base;

  assign adv       = !out_valid_q || pop;
  assign emit      = adv && active_q;
  assign last_byte = (idx_q == total_q - 4'd1);
  assign load      = cmd_valid_i && (!active_q || (emit && last_byte));
  assign cmd_take_o = load;

  // Select the byte at the current step: payload, then CRC low, CRC high.
  always_comb begin
    is_pay    = (idx_q < {1'b0, n_pay_q});
    is_crc_hi = !is_pay && (idx_q != {1'b0, n_pay_q});
    crc_base  = (idx_q == '0 && restart_q) ? mrrf_pkg::CRC_INIT : crc_q;
    if (is_pay) begin
      cur_byte = bytes_q[idx_q[2:0]];
    end else if (is_crc_hi) begin
      cur_byte = crc_base[15:8];
    end else begin
      cur_byte = crc_base[7:0];
    end
  end

  // Sequencer: load the next command and step through its bytes.
  always_comb begin
    crc_d        = crc_q;
    words_left_d = words_left_q;
    frame_open_d = frame_open_q;
    active_d     = active_q;
    idx_d        = idx_q;
    total_d      = total_q;
    n_pay_d      = n_pay_q;
    restart_d    = restart_q;
    feed_d       = feed_q;
    misuse_d     = misuse_q;
    bytes_d      = bytes_q;
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_fend_d   = out_fend_q;
    out_last_d   = out_last_q;
    out_mis_d    = out_mis_q;

    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = cur_byte;
      out_fend_d  = is_crc_hi;
      out_last_d  = last_byte;
      out_mis_d   = misuse_q;
      idx_d       = idx_q + 4'd1;
      if (is_pay && feed_q) begin
        crc_d = crc_byte(crc_base, cur_byte);
      end else if (is_crc_hi) begin
        crc_d = mrrf_pkg::CRC_INIT;
      end
      if (last_byte) begin
        active_d = 1'b0;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end

    if (load) begin
      active_d  = 1'b1;
      idx_d     = '0;
      misuse_d  = 1'b0;
      feed_d    = 1'b1;
      restart_d = 1'b1;
      bytes_d[0] = cmd_i.device;
      bytes_d[1] = cmd_i.func_code;
      bytes_d[2] = cmd_i.reg_address[15:8];
      bytes_d[3] = cmd_i.reg_address[7:0];
      bytes_d[4] = cmd_i.value[15:8];
      bytes_d[5] = cmd_i.value[7:0];
      bytes_d[6] = {cmd_i.value[6:0], 1'b0};
      case (cmd_i.kind)
        mrrf_pkg::KIND_REQUEST: begin
          n_pay_d      = 3'd6;
          total_d      = 4'd8;
          frame_open_d = 1'b0;
          words_left_d = '0;
        end
        mrrf_pkg::KIND_HEADER: begin
          n_pay_d = 3'd7;
          if (cmd_i.value == '0) begin
            total_d      = 4'd9;
            frame_open_d = 1'b0;
          end else begin
            total_d      = 4'd7;
            frame_open_d = 1'b1;
          end
          words_left_d = cmd_i.value;
        end
        mrrf_pkg::KIND_DATA: begin
          restart_d = 1'b0;
          if (!frame_open_q || words_left_q == '0) begin
            // Stray data word: one zero byte flagged as misuse, state untouched.
            misuse_d   = 1'b1;
            feed_d     = 1'b0;
            bytes_d[0] = 8'h00;
            n_pay_d    = 3'd1;
            total_d    = 4'd1;
          end else begin
            bytes_d[0]   = cmd_i.value[15:8];
            bytes_d[1]   = cmd_i.value[7:0];
            n_pay_d      = 3'd2;
            words_left_d = words_left_q - 16'd1;
            if (words_left_q == 16'd1) begin
              total_d      = 4'd4;
              frame_open_d = 1'b0;
            end else begin
              total_d = 4'd2;
            end
          end
        end
        default: begin
          n_pay_d = 3'd6;
          total_d = 4'd8;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q        <= mrrf_pkg::CRC_INIT;
      words_left_q <= '0;
      frame_open_q <= 1'b0;
      active_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      crc_q        <= crc_d;
      words_left_q <= words_left_d;
      frame_open_q <= frame_open_d;
      active_q     <= active_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    total_q    <= total_d;
    n_pay_q    <= n_pay_d;
    restart_q  <= restart_d;
    feed_q     <= feed_d;
    misuse_q   <= misuse_d;
    bytes_q    <= bytes_d;
    out_byte_q <= out_byte_d;
    out_fend_q <= out_fend_d;
    out_last_q <= out_last_d;
    out_mis_q  <= out_mis_d;
  end

  assign empty          = !out_valid_q;
  assign tx_byte_o      = out_byte_q;
  assign frame_end_o    = out_fend_q;
  assign last_of_item_o = out_last_q;
  assign misuse_o       = out_mis_q;

  // A frame always closes on the last byte of its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_end_o) |-> last_of_item_o)
    else $error("frame end not on last byte of request");

  // A misuse result is a lone zero byte outside any frame end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && misuse_o) |-> (last_of_item_o && !frame_end_o && tx_byte_o == 8'h00))
    else $error("malformed misuse result");

  // An open write-multiple frame always has words still due.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_open_q |-> (words_left_q != '0))
    else $error("open frame with no words left");

endmodule

[design/modbus_rtu_request_framer_top.sv]
// An accepted request passes the front queue, the back item registers and the output register
// before its first byte shows. The back gives one frame byte per cycle unless pop stalls it;
// a request makes 1 to 9 bytes; the single byte lane and CRC step of the back set this rate.
// Requests are queued in a short front queue, so push continues while bytes drain.
// Reset is asynchronous and active low: queue and result register empty, no frame open,
// CRC back at its start value.
module modbus_rtu_request_framer_top #(
  parameter int unsigned QueueDepth = mrrf_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  device_i,
  input  logic [15:0] reg_address_i,
  input  logic [15:0] value_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  tx_byte_o,
  output logic        frame_end_o,
  output logic        last_of_item_o,
  output logic        misuse_o
);

  logic           cmd_valid;
  logic           cmd_take;
  mrrf_pkg::cmd_t cmd;

  // Front: accept and classify requests into the queue.
  mrrf_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .opcode_i      (opcode_i),
    .device_i      (device_i),
    .reg_address_i (reg_address_i),
    .value_i       (value_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_take_i    (cmd_take)
  );

  // Back: build frame bytes and CRC, one byte per cycle unless pop stalls the output.
  mrrf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_take_o     (cmd_take),
    .empty          (empty),
    .pop            (pop),
    .tx_byte_o      (tx_byte_o),
    .frame_end_o    (frame_end_o),
    .last_of_item_o (last_of_item_o),
    .misuse_o       (misuse_o)
  );

endmodule

[tb/tb_modbus_rtu_request_framer_top.sv]
`timescale 1ns / 1ps

module tb_modbus_rtu_request_framer_top;

  // Opcodes outside the package enum; the framer must ignore them.
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  localparam int RANDOM_ITEMS = 320;
  localparam int MAX_WAIT     = 17;
  localparam int SETTLE_CYCLES = 40;
  localparam int TIMEOUT_NS   = 8_000_000;

  // One transmitted frame byte with its flags.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       last_of_item;
    logic       misuse;
  } frame_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [2:0]  opcode_i;
  logic [7:0]  device_i;
  logic [15:0] reg_address_i;
  logic [15:0] value_i;
  logic        empty;
  logic        pop;
  logic [7:0]  tx_byte_o;
  logic        frame_end_o;
  logic        last_of_item_o;
  logic        misuse_o;

  // Bytes the framer still owes, oldest first.
  frame_byte_t frame_bytes_due[$];
  // Bytes produced by the request being predicted.
  frame_byte_t request_bytes[$];

  // Predicted framer state.
  logic [15:0] pred_crc;
  logic [15:0] pred_words_left;
  logic        pred_frame_open;

  int unsigned mismatches;
  bit          tx_calm;
  bit          rx_calm;

  modbus_rtu_request_framer_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .opcode_i       (opcode_i),
    .device_i       (device_i),
    .reg_address_i  (reg_address_i),
    .value_i        (value_i),
    .empty          (empty),
    .pop            (pop),
    .tx_byte_o      (tx_byte_o),
    .frame_end_o    (frame_end_o),
    .last_of_item_o (last_of_item_o),
    .misuse_o       (misuse_o)
  );

  // Free-running clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Half of the waits are zero, the rest spread over the full range.
  function automatic int pick_wait();
    if ($urandom_range(0, 1) != 0) return 0;
    return int'($urandom_range(0, MAX_WAIT));
  endfunction

  // One byte through the reflected CRC-16.
  function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ mrrf_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void emit_byte(logic [7:0] data, logic fend, logic mis);
    frame_byte_t fb;
    fb.tx_byte      = data;
    fb.frame_end    = fend;
    fb.last_of_item = 1'b0;
    fb.misuse       = mis;
    request_bytes.push_back(fb);
  endfunction

  // A frame byte also advances the running CRC.
  function automatic void put_frame_byte(logic [7:0] data);
    pred_crc = crc16_next(pred_crc, data);
    emit_byte(data, 1'b0, 1'b0);
  endfunction

  function automatic void put_frame_word(logic [15:0] word);
    put_frame_byte(word[15:8]);
    put_frame_byte(word[7:0]);
  endfunction

  // Append the CRC, low byte first, and close the frame.
  function automatic void close_frame();
    emit_byte(pred_crc[7:0], 1'b0, 1'b0);
    emit_byte(pred_crc[15:8], 1'b1, 1'b0);
    pred_crc        = mrrf_pkg::CRC_INIT;
    pred_words_left = '0;
    pred_frame_open = 1'b0;
  endfunction

  // Any request or header drops an open frame and starts afresh.
  function automatic void open_frame(logic [7:0] dev, logic [7:0] code, logic [15:0] addr);
    pred_crc        = mrrf_pkg::CRC_INIT;
    pred_words_left = '0;
    pred_frame_open = 1'b0;
    put_frame_byte(dev);
    put_frame_byte(code);
    put_frame_word(addr);
  endfunction

  // Work out the bytes one accepted request causes and queue them.
  function automatic void predict_frame_bytes(logic [2:0] op, logic [7:0] dev,
                                              logic [15:0] addr, logic [15:0] val);
    request_bytes.delete();
    case (op)
      mrrf_pkg::OP_READ_HOLDING, mrrf_pkg::OP_READ_INPUT, mrrf_pkg::OP_WRITE_SINGLE: begin
        open_frame(dev,
                   (op == mrrf_pkg::OP_READ_HOLDING) ? mrrf_pkg::FC_READ_HOLDING :
                   (op == mrrf_pkg::OP_READ_INPUT) ? mrrf_pkg::FC_READ_INPUT :
                   mrrf_pkg::FC_WRITE_SINGLE, addr);
        put_frame_word(val);
        close_frame();
      end
      mrrf_pkg::OP_WRITE_MULTI: begin
        open_frame(dev, mrrf_pkg::FC_WRITE_MULTI, addr);
        put_frame_word(val);
        put_frame_byte({val[6:0], 1'b0});
        if (val == '0) begin
          close_frame();
        end else begin
          pred_words_left = val;
          pred_frame_open = 1'b1;
        end
      end
      mrrf_pkg::OP_DATA_WORD: begin
        if (!pred_frame_open || pred_words_left == '0) begin
          emit_byte(8'h00, 1'b0, 1'b1);
        end else begin
          put_frame_word(val);
          pred_words_left = pred_words_left - 16'd1;
          if (pred_words_left == '0) close_frame();
        end
      end
      default: begin
      end
    endcase
    if (request_bytes.size() > 0) request_bytes[$].last_of_item = 1'b1;
    foreach (request_bytes[i]) frame_bytes_due.push_back(request_bytes[i]);
  endfunction

  // Offer one request after a random gap and predict it once accepted.
  task automatic send_request(logic [2:0] op, logic [7:0] dev,
                              logic [15:0] addr, logic [15:0] val);
    int gap;
    gap = tx_calm ? 0 : pick_wait();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push          <= 1'b1;
    opcode_i      <= op;
    device_i      <= dev;
    reg_address_i <= addr;
    value_i       <= val;
    do @(posedge clk_i); while (full);
    predict_frame_bytes(op, dev, addr, val);
  endtask

  // Stop sending until every owed byte has come out.
  task automatic hold_until_drained();
    push <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk_i);
  endtask

  // Stray data words, right after reset and after closed frames.
  task automatic test_stray_words();
    send_request(mrrf_pkg::OP_DATA_WORD, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(mrrf_pkg::OP_WRITE_MULTI, 8'h01, 16'h0000, 16'h0000);
    send_request(mrrf_pkg::OP_DATA_WORD, 8'h00, 16'h0000, 16'h1234);
    hold_until_drained();
  endtask

  // Fixed eight-byte frames with extreme and alternating fields.
  task automatic test_single_frames();
    send_request(mrrf_pkg::OP_READ_HOLDING, 8'h00, 16'h0000, 16'h0000);
    send_request(mrrf_pkg::OP_READ_INPUT, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(mrrf_pkg::OP_WRITE_SINGLE, 8'hA5, 16'h5AA5, 16'hA55A);
    send_request(mrrf_pkg::OP_READ_HOLDING, 8'h11, 16'h006B, 16'h0003);
    hold_until_drained();
  endtask

  // Write-multiple frames: zero count, complete, byte-count wrap, abandoned.
  task automatic test_write_multiple();
    send_request(mrrf_pkg::OP_WRITE_MULTI, 8'hFF, 16'hFFFF, 16'h0000);
    send_request(mrrf_pkg::OP_WRITE_MULTI, 8'h11, 16'h0001, 16'h0002);
    send_request(mrrf_pkg::OP_DATA_WORD, 8'h00, 16'h0000, 16'h000A);
    send_request(mrrf_pkg::OP_DATA_WORD, 8'h00, 16'h0000, 16'h0102);
    // A count of 128 wraps the byte count to zero; a read then abandons it.
    send_request(mrrf_pkg::OP_WRITE_MULTI, 8'h22, 16'h8000, 16'h0080);
    send_request(mrrf_pkg::OP_DATA_WORD, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(mrrf_pkg::OP_DATA_WORD, 8'h00, 16'h0000, 16'h0000);
    send_request(mrrf_pkg::OP_READ_INPUT, 8'h33, 16'h0100, 16'h0010);
    // The largest count, abandoned by a fresh header.
    send_request(mrrf_pkg::OP_WRITE_MULTI, 8'h44, 16'h00FF, 16'hFFFF);
    send_request(mrrf_pkg::OP_DATA_WORD, 8'h00, 16'h0000, 16'h5555);
    send_request(mrrf_pkg::OP_WRITE_MULTI, 8'h55, 16'hFF00, 16'h0001);
    send_request(mrrf_pkg::OP_DATA_WORD, 8'h00, 16'h0000, 16'hAAAA);
    hold_until_drained();
  endtask

  // Unused opcodes inside an open frame and outside one change nothing.
  task automatic test_ignored_opcodes();
    send_request(mrrf_pkg::OP_WRITE_MULTI, 8'h66, 16'h1234, 16'h0001);
    for (logic [3:0] op = 4'(OP_UNUSED_FIRST); op <= 4'(OP_UNUSED_LAST); op++) begin
      send_request(op[2:0], 8'hFF, 16'hFFFF, 16'hFFFF);
    end
    send_request(mrrf_pkg::OP_DATA_WORD, 8'h00, 16'h0000, 16'hBEEF);
    send_request(OP_UNUSED_LAST, 8'h00, 16'h0000, 16'h0000);
    hold_until_drained();
  endtask

  // Mostly small counts, a few with the byte count wrapping.
  function automatic int pick_word_count();
    int r;
    r = $urandom_range(0, 39);
    if (r == 0) return int'($urandom_range(126, 130));
    if (r == 1) return 0;
    if (r < 10) return int'($urandom_range(5, 12));
    return int'($urandom_range(1, 4));
  endfunction

  // Random traffic: mostly well-formed frames, with noise mixed in.
  task automatic test_random_traffic();
    int sent;
    int count;
    int words;
    int pick;
    bit drained;
    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        count = pick_word_count();
        words = count;
        // Now and then the frame is cut short and left open.
        if (count > 0 && $urandom_range(0, 7) == 0) words = $urandom_range(0, count - 1);
        send_request(mrrf_pkg::OP_WRITE_MULTI, 8'($urandom), 16'($urandom), 16'(count));
        for (int w = 0; w < words; w++) begin
          send_request(mrrf_pkg::OP_DATA_WORD, 8'($urandom), 16'($urandom), 16'($urandom));
        end
        sent += 1 + words;
      end else if (pick < 8) begin
        send_request(3'($urandom_range(mrrf_pkg::OP_READ_HOLDING, mrrf_pkg::OP_WRITE_SINGLE)),
                     8'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end else if (pick == 8) begin
        send_request(mrrf_pkg::OP_DATA_WORD, 8'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end else begin
        send_request(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                     8'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        hold_until_drained();
        drained = 1'b1;
      end
    end
    tx_calm = 1'b0;
    hold_until_drained();
  endtask

  // Reset, run each test in turn, then report.
  initial begin
    push          <= 1'b0;
    opcode_i      <= '0;
    device_i      <= '0;
    reg_address_i <= '0;
    value_i       <= '0;
    rst_ni        <= 1'b0;
    mismatches     = 0;
    tx_calm        = 1'b0;
    pred_crc        = mrrf_pkg::CRC_INIT;
    pred_words_left = '0;
    pred_frame_open = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_stray_words();
    test_single_frames();
    test_write_multiple();
    test_ignored_opcodes();
    test_random_traffic();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_modbus_rtu_request_framer_top: clean");
    end else begin
      $display("tb_modbus_rtu_request_framer_top: errors");
    end
    $finish;
  end

  // Result side: random stalls, with calm stretches that flip now and then.
  initial begin
    int stall;
    pop    <= 1'b0;
    rx_calm = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : pick_wait();
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %02h, got %02h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Compare every popped byte with the oldest owed one.
  always @(posedge clk_i) begin
    frame_byte_t want;
    if (pop && !empty) begin
      if (frame_bytes_due.size() == 0) begin
        $display("%0t: unexpected byte, expected none, got %02h end %0b last %0b misuse %0b",
                 $time, tx_byte_o, frame_end_o, last_of_item_o, misuse_o);
        mismatches++;
      end else begin
        want = frame_bytes_due.pop_front();
        check_field("tx_byte", want.tx_byte, tx_byte_o);
        check_field("frame_end", {7'b0, want.frame_end}, {7'b0, frame_end_o});
        check_field("last_of_item", {7'b0, want.last_of_item}, {7'b0, last_of_item_o});
        check_field("misuse", {7'b0, want.misuse}, {7'b0, misuse_o});
      end
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_modbus_rtu_request_framer_top: errors");
    $finish;
  end

endmodule

[filelist.f]
design/mrrf_pkg.sv
design/mrrf_front.sv
design/mrrf_back.sv
design/modbus_rtu_request_framer_top.sv
tb/tb_modbus_rtu_request_framer_top.sv
